FILE: src/tsrt_pkg.sv
// Package for the time sorted record table: sizes, codes, item and entry types.
// Used by tsrt_table_ram and time_sorted_record_table; depends on nothing else.
package tsrt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 24;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_FIND
  } state_e;

  // Input item.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] flight_id;
    logic [7:0]  hour_tens_char;
    logic [7:0]  hour_ones_char;
    logic [7:0]  minute_tens_char;
    logic [7:0]  minute_ones_char;
    logic [31:0] record_payload;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      found_id;
    logic [7:0]       found_hour_tens;
    logic [7:0]       found_hour_ones;
    logic [7:0]       found_minute_tens;
    logic [7:0]       found_minute_ones;
    logic [31:0]      found_payload;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  // One stored record: hour tens in bits 31..24 of time_chars down to minute ones.
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [31:0]        time_chars;
    logic [31:0]        payload;
  } entry_t;

  // Access command for the table memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_cmd_t;

  // Decodes a digit pair as tens*10+ones of the raw codes. The offset of 48 in
  // each digit shifts every decoded value by the same amount: order is unchanged.
  function automatic logic [11:0] pair_value(logic [7:0] tens, logic [7:0] ones);
    pair_value = 12'(tens) * 12'd10 + 12'(ones);
  endfunction

  // Sort key: hour in the upper half, minute in the lower half.
  function automatic logic [KEY_W-1:0] time_key(logic [31:0] t);
    time_key = {pair_value(t[31:24], t[23:16]), pair_value(t[15:8], t[7:0])};
  endfunction

endpackage

FILE: src/tsrt_table_ram.sv
// Record storage of the time sorted record table: one write and one read port,
// read data registered, so it is valid in the cycle after the read. Depends on tsrt_pkg.
module tsrt_table_ram (
  input  logic              clk_i,
  input  tsrt_pkg::ram_cmd_t cmd_i,
  output tsrt_pkg::entry_t   rdata_o
);
  import tsrt_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[cmd_i.waddr] <= cmd_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.re) begin
      rdata_q <= mem_q[cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/time_sorted_record_table.sv
// Top level of the time sorted record table: sequencer, counters and result register.
// Depends on tsrt_pkg and tsrt_table_ram.
//
//   channel   | handshake            | payload
//   ----------+----------------------+--------------------
//   request   | start high, busy low | req_i  (req_t)
//   result    | done_o, one cycle    | rsp_o  (rsp_t)
//
// An item holds busy for a walk over the table through the single read port
// of the record memory. Insert walks from the tail down to the insert place;
// remove and search walk the whole table; a full insert, an unknown code or an
// empty table needs no walk. The result appears in the cycle after the last step.
// Reset clears the count and the sequencer; the memory is not cleared.
// The result is shown for one cycle only, since the receiver cannot stall.
module time_sorted_record_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tsrt_pkg::req_t  req_i,
  output logic            done_o,
  output tsrt_pkg::rsp_t  rsp_o
);
  import tsrt_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             remove_q, remove_d;
  logic             hit_q, hit_d;
  entry_t           hit_ent_q, hit_ent_d;
  entry_t           new_q, new_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  ram_cmd_t         cmd;
  entry_t           rdata;
  logic             accept;
  entry_t           req_ent;

  // Record memory. Insert walks downward and writes one place above the read,
  // remove walks upward and writes one place below, so no read ever meets a
  // pending write to the same entry.
  tsrt_table_ram u_ram (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .rdata_o (rdata)
  );

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign req_ent.id         = ID_BITS'(req_i.flight_id);
  assign req_ent.time_chars = {req_i.hour_tens_char, req_i.hour_ones_char,
                               req_i.minute_tens_char, req_i.minute_ones_char};
  assign req_ent.payload    = req_i.record_payload;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    remove_q  <= remove_d;
    hit_q     <= hit_d;
    hit_ent_q <= hit_ent_d;
    new_q     <= new_d;
    key_q     <= key_d;
    rsp_q     <= rsp_d;
  end

  // Sequencer: next state, memory commands and result.
  always_comb begin
    logic   finish;
    logic   hit_f;
    entry_t ent_f;
    finish    = 1'b0;
    hit_f     = 1'b0;
    ent_f     = '0;
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    remove_d  = remove_q;
    hit_d     = hit_q;
    hit_ent_d = hit_ent_q;
    new_d     = new_q;
    key_d     = key_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    cmd       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          new_d    = req_ent;
          key_d    = time_key(req_ent.time_chars);
          remove_d = (req_i.operation == OP_REMOVE);
          hit_d    = 1'b0;
          hit_ent_d = '0;
          rsp_d    = '0;
          if (req_i.operation == OP_INSERT) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              // Full table: report and leave the contents alone.
              done_d            = 1'b1;
              rsp_d.status      = ST_FULL;
              rsp_d.entry_count = count_q;
            end else if (count_q == '0) begin
              // Empty table: the new record goes straight to the head.
              cmd.we            = 1'b1;
              cmd.waddr         = '0;
              cmd.wdata         = req_ent;
              count_d           = CNT_W'(1);
              done_d            = 1'b1;
              rsp_d.status      = ST_DONE;
              rsp_d.entry_count = CNT_W'(1);
            end else begin
              cmd.re  = 1'b1;
              cmd.raddr = IDX_W'(count_q - CNT_W'(1));
              idx_d   = IDX_W'(count_q - CNT_W'(1));
              state_d = S_INS;
            end
          end else if ((req_i.operation == OP_REMOVE || req_i.operation == OP_SEARCH)
                       && count_q != '0) begin
            cmd.re    = 1'b1;
            cmd.raddr = '0;
            idx_d     = '0;
            state_d   = S_FIND;
          end else begin
            // Empty table or unused code: nothing found.
            done_d            = 1'b1;
            rsp_d.status      = ST_NOT_FOUND;
            rsp_d.entry_count = count_q;
          end
        end
      end

      S_INS: begin
        // The table is sorted, so walking from the tail moves every entry whose
        // key is not below the new one up by one place.
        if (time_key(rdata.time_chars) >= key_q) begin
          cmd.we    = 1'b1;
          cmd.waddr = IDX_W'(idx_q + IDX_W'(1));
          cmd.wdata = rdata;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            cmd.re    = 1'b1;
            cmd.raddr = idx_q - IDX_W'(1);
            idx_d     = idx_q - IDX_W'(1);
          end
        end else begin
          cmd.we    = 1'b1;
          cmd.waddr = IDX_W'(idx_q + IDX_W'(1));
          cmd.wdata = new_q;
          finish    = 1'b1;
        end
      end

      S_PUT: begin
        // Every entry moved up: the new record takes the head.
        cmd.we    = 1'b1;
        cmd.waddr = '0;
        cmd.wdata = new_q;
        finish    = 1'b1;
      end

      S_FIND: begin
        if (remove_q && hit_q) begin
          // Close the gap left by the removed record.
          cmd.we    = 1'b1;
          cmd.waddr = idx_q - IDX_W'(1);
          cmd.wdata = rdata;
        end else if (rdata.id == new_q.id) begin
          // Remove keeps the first match, search the last one.
          hit_d     = 1'b1;
          hit_ent_d = rdata;
        end
        if (CNT_W'(idx_q) == count_q - CNT_W'(1)) begin
          hit_f = hit_d;
          ent_f = hit_ent_d;
          done_d       = 1'b1;
          rsp_d.status = hit_f ? ST_DONE : ST_NOT_FOUND;
          if (hit_f) begin
            rsp_d.found_id          = 16'(ent_f.id);
            rsp_d.found_hour_tens   = ent_f.time_chars[31:24];
            rsp_d.found_hour_ones   = ent_f.time_chars[23:16];
            rsp_d.found_minute_tens = ent_f.time_chars[15:8];
            rsp_d.found_minute_ones = ent_f.time_chars[7:0];
            rsp_d.found_payload     = ent_f.payload;
          end
          if (remove_q && hit_f) begin
            count_d = count_q - CNT_W'(1);
          end
          rsp_d.entry_count = count_d;
          state_d = S_IDLE;
        end else begin
          cmd.re    = 1'b1;
          cmd.raddr = IDX_W'(idx_q + IDX_W'(1));
          idx_d     = IDX_W'(idx_q + IDX_W'(1));
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Completion of an insert walk.
    if (finish) begin
      count_d           = count_q + CNT_W'(1);
      done_d            = 1'b1;
      rsp_d             = '0;
      rsp_d.status      = ST_DONE;
      rsp_d.entry_count = count_q + CNT_W'(1);
      state_d           = S_IDLE;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // The count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("record count above table depth");

  // A walk only runs over a table that holds at least one record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q != '0))
    else $error("table walk on an empty table");

  // A result is only shown once the walk has ended.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // An insert into a full table is answered at once with the full status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.operation == OP_INSERT && count_q == CNT_W'(TABLE_DEPTH))
    |=> (done_o && rsp_o.status == ST_FULL && !busy))
    else $error("full insert not answered with full status");

endmodule
